[rtl/rgbh_pkg.sv]
// Shared types and constants for the RGB and luma histogram unit.
// No dependencies; every other file in rtl/ except rgbh_ram imports this package.
`default_nettype none

package rgbh_pkg;

  // Histogram geometry
  localparam int COUNT_BITS = 24;
  localparam int BIN_BITS   = 8;
  localparam int NUM_BINS   = 1 << BIN_BITS;
  localparam int NUM_HIST   = 4;

  // Histogram slots
  localparam int HIST_BLUE  = 0;
  localparam int HIST_GREEN = 1;
  localparam int HIST_RED   = 2;
  localparam int HIST_GRAY  = 3;

  // Luma weights, 0.21 / 0.72 / 0.07 in 16-bit fixed point
  localparam int GRAY_SUM_BITS = 24;
  localparam int GRAY_SHIFT    = 16;
  localparam logic [15:0] COEF_RED   = 16'd13763;
  localparam logic [15:0] COEF_GREEN = 16'd47186;
  localparam logic [15:0] COEF_BLUE  = 16'd4588;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  // Command codes
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [BIN_BITS-1:0]   bin_t;

  localparam count_t COUNT_MAX = '1;

  // One classified word: command plus the bin address for each histogram.
  // For a pixel the gray slot also carries the luma value to return.
  typedef struct packed {
    logic                       cmd;
    logic [NUM_HIST-1:0][BIN_BITS-1:0] addr;
  } entry_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_UPDATE
  } back_state_t;

endpackage

`default_nettype wire

[rtl/rgbh_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module rgbh_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[rtl/rgbh_front.sv]
// Front end: accepts input words, forms luma products and bin addresses.
// Depends on rgbh_pkg.
`default_nettype none

module rgbh_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  output      logic            full,
  input  wire logic            in_cmd,
  input  wire rgbh_pkg::bin_t  in_blue,
  input  wire rgbh_pkg::bin_t  in_green,
  input  wire rgbh_pkg::bin_t  in_red,
  input  wire rgbh_pkg::bin_t  in_bin,
  output      logic            q_push,
  output      rgbh_pkg::entry_t q_entry,
  input  wire logic            q_full
);

  import rgbh_pkg::*;

  logic                     f_valid_r;
  logic                     f_cmd_r;
  bin_t                     f_blue_r;
  bin_t                     f_green_r;
  bin_t                     f_red_r;
  bin_t                     f_bin_r;
  logic [GRAY_SUM_BITS-1:0] p_red_r;
  logic [GRAY_SUM_BITS-1:0] p_green_r;
  logic [GRAY_SUM_BITS-1:0] p_blue_r;
  logic [GRAY_SUM_BITS-1:0] sum;
  logic                     accept;

  // Hold the stage while the queue is full
  assign q_push = f_valid_r && !q_full;
  assign full   = f_valid_r && q_full;
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (accept) begin
      f_valid_r <= 1'b1;
    end else if (q_push) begin
      f_valid_r <= 1'b0;
    end
  end

  // Capture word and weighted channel products
  always_ff @(posedge clk) begin
    if (accept) begin
      f_cmd_r   <= in_cmd;
      f_blue_r  <= in_blue;
      f_green_r <= in_green;
      f_red_r   <= in_red;
      f_bin_r   <= in_bin;
      p_red_r   <= GRAY_SUM_BITS'(COEF_RED)   * GRAY_SUM_BITS'(in_red);
      p_green_r <= GRAY_SUM_BITS'(COEF_GREEN) * GRAY_SUM_BITS'(in_green);
      p_blue_r  <= GRAY_SUM_BITS'(COEF_BLUE)  * GRAY_SUM_BITS'(in_blue);
    end
  end

  // Sum never exceeds 65537*255, so it fits without wrap
  assign sum = p_red_r + p_green_r + p_blue_r;

  // Classify: pixels address each channel's bin, reads address one bin in all
  always_comb begin
    q_entry.cmd = f_cmd_r;
    if (f_cmd_r == CMD_PIXEL) begin
      q_entry.addr[HIST_BLUE]  = f_blue_r;
      q_entry.addr[HIST_GREEN] = f_green_r;
      q_entry.addr[HIST_RED]   = f_red_r;
      q_entry.addr[HIST_GRAY]  = sum[GRAY_SHIFT +: BIN_BITS];
    end else begin
      q_entry.addr[HIST_BLUE]  = f_bin_r;
      q_entry.addr[HIST_GREEN] = f_bin_r;
      q_entry.addr[HIST_RED]   = f_bin_r;
      q_entry.addr[HIST_GRAY]  = f_bin_r;
    end
  end

endmodule

`default_nettype wire

[rtl/rgbh_queue.sv]
// Short FIFO of classified words between front and back.
// Depends on rgbh_pkg.
`default_nettype none

module rgbh_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire rgbh_pkg::entry_t wdata,
  output      logic             q_full,
  input  wire logic             rd_en,
  output      rgbh_pkg::entry_t rdata,
  output      logic             q_empty
);

  import rgbh_pkg::*;

  entry_t               slot_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r;
  logic [QPTR_BITS-1:0] rd_ptr_r;
  logic [QPTR_BITS:0]   cnt_r;
  logic                 do_wr;
  logic                 do_rd;

  assign q_full  = (cnt_r == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rdata   = slot_r[rd_ptr_r];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + QPTR_BITS'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + QPTR_BITS'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + (QPTR_BITS+1)'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - (QPTR_BITS+1)'(1);
      end
    end
  end

  // Store word
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

[rtl/rgbh_back.sv]
// Back end: histogram RAMs, clearing pass, update sequencer, result register.
// Depends on rgbh_pkg and rgbh_ram.
`default_nettype none

module rgbh_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire rgbh_pkg::entry_t q_head,
  input  wire logic             q_empty,
  output      logic             q_pop,
  output      logic             empty,
  input  wire logic             pop,
  output      rgbh_pkg::bin_t   out_gray,
  output      rgbh_pkg::count_t out_count_blue,
  output      rgbh_pkg::count_t out_count_green,
  output      rgbh_pkg::count_t out_count_red,
  output      rgbh_pkg::count_t out_count_gray
);

  import rgbh_pkg::*;

  back_state_t         state_r;
  back_state_t         state_nxt;
  bin_t                clr_addr_r;
  bin_t                clr_addr_nxt;
  entry_t              cur_r;
  count_t              rd_data [NUM_HIST];
  count_t              incr    [NUM_HIST];
  bin_t                wr_addr [NUM_HIST];
  count_t              wr_data [NUM_HIST];
  logic                ram_re;
  logic                ram_we;
  logic                ram_clr;
  logic                ld_out;
  logic                out_valid_r;
  bin_t                out_gray_r;
  count_t              out_cnt_r [NUM_HIST];

  // Histogram memories and saturating increment
  for (genvar h = 0; h < NUM_HIST; h++) begin : g_hist
    rgbh_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (NUM_BINS)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we),
      .waddr (wr_addr[h]),
      .wdata (wr_data[h]),
      .re    (ram_re),
      .raddr (q_head.addr[h]),
      .rdata (rd_data[h])
    );

    // Write zero during the clearing pass, the bumped count otherwise
    assign wr_addr[h] = ram_clr ? clr_addr_r : cur_r.addr[h];
    assign wr_data[h] = ram_clr ? '0 : incr[h];
    assign incr[h]    = (rd_data[h] == COUNT_MAX) ? rd_data[h]
                                                  : rd_data[h] + count_t'(1);
  end

  // Capture the word alongside the RAM read
  always_ff @(posedge clk) begin
    if (ram_re) begin
      cur_r <= q_head;
    end
  end

  // Sequencer state and clearing address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // Clear every bin after reset, then read in idle, write back (pixels only) and emit
  // in update once the result slot frees
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    q_pop        = 1'b0;
    ram_re       = 1'b0;
    ram_we       = 1'b0;
    ram_clr      = 1'b0;
    ld_out       = 1'b0;
    unique case (state_r)
      BK_CLEAR: begin
        ram_we       = 1'b1;
        ram_clr      = 1'b1;
        clr_addr_nxt = clr_addr_r + bin_t'(1);
        if (clr_addr_r == bin_t'(NUM_BINS - 1)) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          ram_re    = 1'b1;
          state_nxt = BK_UPDATE;
        end
      end
      BK_UPDATE: begin
        if (!out_valid_r || pop) begin
          ld_out    = 1'b1;
          ram_we    = (cur_r.cmd == CMD_PIXEL);
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld_out) begin
      out_valid_r <= 1'b1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      if (cur_r.cmd == CMD_PIXEL) begin
        out_gray_r <= cur_r.addr[HIST_GRAY];
        for (int h = 0; h < NUM_HIST; h++) begin
          out_cnt_r[h] <= '0;
        end
      end else begin
        out_gray_r <= '0;
        for (int h = 0; h < NUM_HIST; h++) begin
          out_cnt_r[h] <= rd_data[h];
        end
      end
    end
  end

  assign empty           = !out_valid_r;
  assign out_gray        = out_gray_r;
  assign out_count_blue  = out_cnt_r[HIST_BLUE];
  assign out_count_green = out_cnt_r[HIST_GREEN];
  assign out_count_red   = out_cnt_r[HIST_RED];
  assign out_count_gray  = out_cnt_r[HIST_GRAY];

endmodule

`default_nettype wire

[rtl/rgb_and_luma_histogram_unit.sv]
// Top level of the RGB and luma histogram unit: front end, queue, back end.
// Depends on rgbh_pkg, rgbh_front, rgbh_queue and rgbh_back.
//
//   channel  | handshake          | word
//   ---------+--------------------+---------------------------------------------
//   input    | push / full        | in_cmd, in_blue, in_green, in_red, in_bin
//   result   | empty / pop        | out_gray, out_count_blue/green/red/gray
//
// For each word the back end reads the four histogram RAMs in idle (registered
// read), then in update writes the saturated counts back for a pixel and loads
// the result register. It takes no new word until update has finished the last
// one. After reset the back end writes zero to every bin before it takes a word;
// the front end and queue still accept up to three words meanwhile. A stalled
// result holds the back end, and the front end keeps accepting until its stage
// and the queue fill.
`default_nettype none

module rgb_and_luma_histogram_unit (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output      logic             full,
  input  wire logic             in_cmd,
  input  wire rgbh_pkg::bin_t   in_blue,
  input  wire rgbh_pkg::bin_t   in_green,
  input  wire rgbh_pkg::bin_t   in_red,
  input  wire rgbh_pkg::bin_t   in_bin,
  output      logic             empty,
  input  wire logic             pop,
  output      rgbh_pkg::bin_t   out_gray,
  output      rgbh_pkg::count_t out_count_blue,
  output      rgbh_pkg::count_t out_count_green,
  output      rgbh_pkg::count_t out_count_red,
  output      rgbh_pkg::count_t out_count_gray
);

  import rgbh_pkg::*;

  logic   q_push;
  logic   q_full;
  logic   q_pop;
  logic   q_empty;
  entry_t q_entry;
  entry_t q_head;

  rgbh_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_cmd   (in_cmd),
    .in_blue  (in_blue),
    .in_green (in_green),
    .in_red   (in_red),
    .in_bin   (in_bin),
    .q_push   (q_push),
    .q_entry  (q_entry),
    .q_full   (q_full)
  );

  rgbh_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wdata   (q_entry),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rdata   (q_head),
    .q_empty (q_empty)
  );

  rgbh_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_head          (q_head),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .empty           (empty),
    .pop             (pop),
    .out_gray        (out_gray),
    .out_count_blue  (out_count_blue),
    .out_count_green (out_count_green),
    .out_count_red   (out_count_red),
    .out_count_gray  (out_count_gray)
  );

endmodule

`default_nettype wire

[tb/rgbh_checker.sv]
// Checker for the RGB and luma histogram unit: watches both queue ports,
// keeps its own four histograms and compares every popped result word.
// Depends on rgbh_pkg for widths and bin geometry.
`timescale 1ns / 1ps

module rgbh_checker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic             full,
  input  logic             in_cmd,
  input  rgbh_pkg::bin_t   in_blue,
  input  rgbh_pkg::bin_t   in_green,
  input  rgbh_pkg::bin_t   in_red,
  input  rgbh_pkg::bin_t   in_bin,
  input  logic             empty,
  input  logic             pop,
  input  rgbh_pkg::bin_t   out_gray,
  input  rgbh_pkg::count_t out_count_blue,
  input  rgbh_pkg::count_t out_count_green,
  input  rgbh_pkg::count_t out_count_red,
  input  rgbh_pkg::count_t out_count_gray,
  output int               fail_count,
  output int               pending,
  output int               pixels_seen,
  output int               reads_seen,
  output int               deepest_count
);
  import rgbh_pkg::*;

  // Luma weights in 16-bit fixed point
  localparam int unsigned W_RED   = 13763;
  localparam int unsigned W_GREEN = 47186;
  localparam int unsigned W_BLUE  = 4588;

  typedef struct packed {
    bin_t   gray;
    count_t blue;
    count_t green;
    count_t red;
    count_t luma;
  } readout_t;

  count_t   tally [NUM_HIST][NUM_BINS];
  readout_t due_results [$];
  int       fails;
  int       n_pix;
  int       n_read;
  int       n_checked;
  int       deepest;

  function automatic bin_t luma_of(bin_t r, bin_t g, bin_t b);
    int unsigned sum;
    sum = W_RED * r + W_GREEN * g + W_BLUE * b;
    return bin_t'(sum >> 16);
  endfunction

  // Saturating increment of one count
  function automatic count_t bumped(count_t c);
    return (c == {COUNT_BITS{1'b1}}) ? c : c + 1'b1;
  endfunction

  always @(posedge clk) begin
    readout_t got;
    readout_t want;
    bin_t     y;
    if (!rst_n) begin
      for (int i = 0; i < NUM_BINS; i++) begin
        for (int h = 0; h < NUM_HIST; h++) tally[h][i] = '0;
      end
      due_results.delete();
      fails = 0;
      n_pix = 0;
      n_read = 0;
      n_checked = 0;
      deepest = 0;
    end else begin
      // Compare the popped word against the oldest prediction
      if (pop && !empty) begin
        got = '{gray: out_gray, blue: out_count_blue, green: out_count_green,
                red: out_count_red, luma: out_count_gray};
        if (due_results.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected result word gray=%0d counts b=%0d g=%0d r=%0d y=%0d",
                     $time, got.gray, got.blue, got.green, got.red, got.luma);
        end else begin
          want = due_results.pop_front();
          if (got.gray !== want.gray || got.blue !== want.blue ||
              got.green !== want.green || got.red !== want.red ||
              got.luma !== want.luma) begin
            fails++;
            if (fails <= 10) begin
              $display("%0t: mismatch on result word %0d", $time, n_checked);
              $display("  expected gray=%0d counts b=%0d g=%0d r=%0d y=%0d",
                       want.gray, want.blue, want.green, want.red, want.luma);
              $display("  actual   gray=%0d counts b=%0d g=%0d r=%0d y=%0d",
                       got.gray, got.blue, got.green, got.red, got.luma);
            end
          end
          n_checked++;
        end
      end
      // Predict the result of the accepted word and advance the histograms
      if (push && !full) begin
        want = '0;
        if (in_cmd == CMD_PIXEL) begin
          y = luma_of(in_red, in_green, in_blue);
          tally[HIST_BLUE][in_blue]   = bumped(tally[HIST_BLUE][in_blue]);
          tally[HIST_GREEN][in_green] = bumped(tally[HIST_GREEN][in_green]);
          tally[HIST_RED][in_red]     = bumped(tally[HIST_RED][in_red]);
          tally[HIST_GRAY][y]         = bumped(tally[HIST_GRAY][y]);
          want.gray = y;
          n_pix++;
        end else begin
          want.blue  = tally[HIST_BLUE][in_bin];
          want.green = tally[HIST_GREEN][in_bin];
          want.red   = tally[HIST_RED][in_bin];
          want.luma  = tally[HIST_GRAY][in_bin];
          for (int h = 0; h < NUM_HIST; h++) begin
            if (int'(tally[h][in_bin]) > deepest) deepest = int'(tally[h][in_bin]);
          end
          n_read++;
        end
        due_results.push_back(want);
      end
    end
    fail_count    <= fails;
    pending       <= due_results.size();
    pixels_seen   <= n_pix;
    reads_seen    <= n_read;
    deepest_count <= deepest;
  end

endmodule

[tb/testbench.sv]
// Top of the histogram unit testbench: clock, reset, word stimulus on the
// input queue port, random popping of results, watchdog and verdict.
// Depends on rgbh_pkg, rgb_and_luma_histogram_unit and rgbh_checker.
`timescale 1ns / 1ps

module testbench;
  import rgbh_pkg::*;

  localparam int RANDOM_WORDS = 1130;
  localparam int DRAIN_AT     = 600;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 150;
  localparam int IDLE_LIMIT   = 3000;
  localparam int TAIL_CYCLES  = 20;

  logic   clk = 1'b0;
  logic   rst_n;
  logic   push;
  logic   full;
  logic   in_cmd;
  bin_t   in_blue;
  bin_t   in_green;
  bin_t   in_red;
  bin_t   in_bin;
  logic   empty;
  logic   pop;
  bin_t   out_gray;
  count_t out_count_blue;
  count_t out_count_green;
  count_t out_count_red;
  count_t out_count_gray;

  int fail_count;
  int pending;
  int pixels_seen;
  int reads_seen;
  int deepest_count;

  bit   burst;
  bin_t pal_b [8];
  bin_t pal_g [8];
  bin_t pal_r [8];

  always #5 clk = ~clk;

  rgb_and_luma_histogram_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_cmd          (in_cmd),
    .in_blue         (in_blue),
    .in_green        (in_green),
    .in_red          (in_red),
    .in_bin          (in_bin),
    .empty           (empty),
    .pop             (pop),
    .out_gray        (out_gray),
    .out_count_blue  (out_count_blue),
    .out_count_green (out_count_green),
    .out_count_red   (out_count_red),
    .out_count_gray  (out_count_gray)
  );

  rgbh_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_cmd          (in_cmd),
    .in_blue         (in_blue),
    .in_green        (in_green),
    .in_red          (in_red),
    .in_bin          (in_bin),
    .empty           (empty),
    .pop             (pop),
    .out_gray        (out_gray),
    .out_count_blue  (out_count_blue),
    .out_count_green (out_count_green),
    .out_count_red   (out_count_red),
    .out_count_gray  (out_count_gray),
    .fail_count      (fail_count),
    .pending         (pending),
    .pixels_seen     (pixels_seen),
    .reads_seen      (reads_seen),
    .deepest_count   (deepest_count)
  );

  // Offer one word after a random gap and hold it until accepted
  task automatic send_word(input logic cmd, input bin_t b, input bin_t g,
                           input bin_t r, input bin_t idx);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push     <= 1'b1;
    in_cmd   <= cmd;
    in_blue  <= b;
    in_green <= g;
    in_red   <= r;
    in_bin   <= idx;
    do @(posedge clk); while (full);
  endtask

  // Stop offering and wait until every predicted result has been popped
  task automatic drain_results();
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Stimulus and verdict
  initial begin : word_source
    int k;
    bin_t pick;
    rst_n    <= 1'b0;
    push     <= 1'b0;
    in_cmd   <= CMD_PIXEL;
    in_blue  <= '0;
    in_green <= '0;
    in_red   <= '0;
    in_bin   <= '0;
    burst = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty bins, extreme and primary colors, ignored fields
    send_word(CMD_READ,  8'hFF, 8'hAA, 8'h55, 8'h00);
    send_word(CMD_READ,  8'h00, 8'h00, 8'h00, 8'hFF);
    send_word(CMD_PIXEL, 8'h00, 8'h00, 8'h00, 8'hFF);
    send_word(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'h00);
    send_word(CMD_PIXEL, 8'hFF, 8'h00, 8'h00, 8'hA5);
    send_word(CMD_PIXEL, 8'h00, 8'hFF, 8'h00, 8'h5A);
    send_word(CMD_PIXEL, 8'h00, 8'h00, 8'hFF, 8'h00);
    send_word(CMD_PIXEL, 8'h01, 8'h01, 8'h01, 8'h00);
    send_word(CMD_PIXEL, 8'h55, 8'hAA, 8'h55, 8'hFF);
    send_word(CMD_PIXEL, 8'hAA, 8'h55, 8'hAA, 8'h00);
    send_word(CMD_PIXEL, 8'h80, 8'h80, 8'h80, 8'h00);
    // Back-to-back hits on the same bins
    burst = 1'b1;
    repeat (4) send_word(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'h00);
    send_word(CMD_READ,  8'h12, 8'h34, 8'h56, 8'hFF);
    send_word(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'h00);
    send_word(CMD_READ,  8'h00, 8'h00, 8'h00, 8'hFF);
    burst = 1'b0;
    send_word(CMD_READ,  8'hFF, 8'hFF, 8'hFF, 8'h00);
    send_word(CMD_READ,  8'h00, 8'h00, 8'h00, 8'd17);
    send_word(CMD_READ,  8'h00, 8'h00, 8'h00, 8'h80);
    drain_results();

    // Random: pixels half from a small palette so bins grow deep
    for (int i = 0; i < 8; i++) begin
      pal_b[i] = bin_t'($urandom);
      pal_g[i] = bin_t'($urandom);
      pal_r[i] = bin_t'($urandom);
    end
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 50 == 0) burst = ($urandom_range(0, 3) == 0);
      if (n == DRAIN_AT) drain_results();
      k = $urandom_range(0, 7);
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 1) == 0)
          send_word(CMD_PIXEL, pal_b[k], pal_g[k], pal_r[k], bin_t'($urandom));
        else
          send_word(CMD_PIXEL, bin_t'($urandom), bin_t'($urandom),
                    bin_t'($urandom), bin_t'($urandom));
      end else begin
        case ($urandom_range(0, 3))
          0: pick = pal_b[k];
          1: pick = pal_g[k];
          2: pick = pal_r[k];
          default: pick = bin_t'($urandom);
        endcase
        send_word(CMD_READ, bin_t'($urandom), bin_t'($urandom),
                  bin_t'($urandom), pick);
      end
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d pixel words and %0d bin reads; deepest count read back %0d.",
             pixels_seen, reads_seen, deepest_count);
    $display("Run included a long result hold-off with input stall and full drains.");
    if (fail_count == 0) begin
      $display("[rgb_and_luma_histogram_unit] OK");
    end else begin
      $display("[rgb_and_luma_histogram_unit] ERROR");
    end
    $finish;
  end

  // Pop results with random gaps, one long hold-off to back up the input
  initial begin : result_sink
    int  gap;
    int  taken;
    bit  steady;
    pop <= 1'b0;
    taken = 0;
    steady = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (taken % 64 == 0) steady = ($urandom_range(0, 3) == 0);
      gap = steady ? 0 : $urandom_range(0, 10);
      if (taken == HOLD_AT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      taken++;
    end
  end

  // Abort when neither port moves a word for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst_n === 1'b1 && ((push && !full) || (pop && !empty)))
        idle = 0;
      else
        idle++;
    end
    $display("Watchdog: no word moved for %0d cycles", IDLE_LIMIT);
    $display("[rgb_and_luma_histogram_unit] ERROR");
    $finish;
  end

endmodule

[sim.f]
rtl/rgbh_pkg.sv
rtl/rgbh_ram.sv
rtl/rgbh_front.sv
rtl/rgbh_queue.sv
rtl/rgbh_back.sv
rtl/rgb_and_luma_histogram_unit.sv
tb/rgbh_checker.sv
tb/testbench.sv
